FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with asynchronous active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition must never be true at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

FILE: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_ESCAPE = 3'd1,
		ERR_BAD_HEX    = 3'd2,
		ERR_LONE_LOW   = 3'd3,
		ERR_NO_SECOND  = 3'd4,
		ERR_NOT_PAIR   = 3'd5,
		ERR_EARLY_END  = 3'd6
	} err_code_t;

	// one request from the front end: one to four result items
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		err_code_t       err;
		logic            done;
		logic            frc;
	} res_cmd_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CODE_BS   = 8'h08;
	localparam logic [7:0] CODE_FF   = 8'h0C;
	localparam logic [7:0] CODE_LF   = 8'h0A;
	localparam logic [7:0] CODE_CR   = 8'h0D;
	localparam logic [7:0] CODE_TAB  = 8'h09;
	localparam logic [15:0] CP_ASCII_END = 16'h0080;

endpackage

FILE: src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: classifies each body byte, tracks escape state and builds
// one request of up to four UTF-8 result items for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_ready,
	output logic              q_push,
	output jsu_pkg::res_cmd_t q_cmd
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_HEX1,
		MODE_EXP_BS,
		MODE_EXP_U,
		MODE_HEX2
	} mode_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
	} enc_t;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

	function automatic enc_t utf8_enc(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.bytes[0] = cp[7:0];
			e.n = 3'd1;
		end else if (cp < 21'h800) begin
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
			e.n = 3'd2;
		end else if (cp < 21'h10000) begin
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
			e.n = 3'd3;
		end else begin
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
			e.n = 3'd4;
		end
		return e;
	endfunction

	mode_t       mode_q, mode_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] hi_q, hi_d;
	logic [1:0]  dc_q, dc_d;
	logic        frc_q, frc_d;
	logic        err_lat_q, err_lat_d;
	logic        utf8_q;

	logic [4:0]  hv;
	logic [15:0] acc_sh;
	logic [20:0] pair_cp;
	enc_t        enc;
	err_code_t   err;
	logic        push;
	logic        accept;

	assign in_ready = q_ready;
	assign accept   = in_valid & in_ready;
	assign q_push   = accept & push;

	assign hv      = hex_val(in_byte);
	assign acc_sh  = {acc_q[11:0], hv[3:0]};
	assign pair_cp = 21'h10000 + {1'b0, hi_q[9:0], acc_sh[9:0]};

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		hi_d      = hi_q;
		dc_d      = dc_q;
		frc_d     = frc_q;
		err_lat_d = err_lat_q;
		enc       = '0;
		err       = ERR_NONE;
		push      = 1'b0;
		q_cmd     = '0;
		if (err_lat_q) begin
			if (in_last) err_lat_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_PLAIN: begin
					if (in_byte == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						enc.bytes[0] = in_byte;
						enc.n = 3'd1;
					end
				end
				MODE_ESC: begin
					mode_d = MODE_PLAIN;
					enc.n = 3'd1;
					case (in_byte)
						CH_BSLASH, CH_SLASH, CH_QUOTE: enc.bytes[0] = in_byte;
						CH_LC_B: enc.bytes[0] = CODE_BS;
						CH_LC_F: enc.bytes[0] = CODE_FF;
						CH_LC_N: enc.bytes[0] = CODE_LF;
						CH_LC_R: enc.bytes[0] = CODE_CR;
						CH_LC_T: enc.bytes[0] = CODE_TAB;
						CH_LC_U: begin
							enc.n = 3'd0;
							mode_d = MODE_HEX1;
							acc_d = '0;
							dc_d = '0;
						end
						default: begin
							enc.n = 3'd0;
							err = ERR_BAD_ESCAPE;
						end
					endcase
				end
				MODE_HEX1, MODE_HEX2: begin
					if (!hv[4]) begin
						err = ERR_BAD_HEX;
					end else begin
						acc_d = acc_sh;
						if (dc_q != 2'd3) begin
							dc_d = dc_q + 2'd1;
						end else begin
							dc_d = '0;
							if (mode_q == MODE_HEX1) begin
								if (acc_sh[15:10] == 6'b110110) begin
									hi_d = acc_sh;
									mode_d = MODE_EXP_BS;
								end else if (acc_sh[15:10] == 6'b110111) begin
									err = ERR_LONE_LOW;
								end else begin
									enc = utf8_enc({5'd0, acc_sh});
									if (acc_sh >= CP_ASCII_END && !utf8_q) frc_d = 1'b1;
									mode_d = MODE_PLAIN;
								end
							end else begin
								if (acc_sh[15:10] == 6'b110111) begin
									enc = utf8_enc(pair_cp);
									if (!utf8_q) frc_d = 1'b1;
									mode_d = MODE_PLAIN;
								end else begin
									err = ERR_NOT_PAIR;
								end
							end
						end
					end
				end
				MODE_EXP_BS: begin
					if (in_byte == CH_BSLASH) mode_d = MODE_EXP_U;
					else err = ERR_NO_SECOND;
				end
				MODE_EXP_U: begin
					if (in_byte == CH_LC_U) begin
						mode_d = MODE_HEX2;
						acc_d = '0;
						dc_d = '0;
					end else begin
						err = ERR_NO_SECOND;
					end
				end
				default: begin
					mode_d = MODE_PLAIN;
					acc_d = '0;
					hi_d = '0;
					dc_d = '0;
					enc.bytes[0] = in_byte;
					enc.n = 3'd1;
				end
			endcase

			if (err == ERR_NONE && in_last && mode_d != MODE_PLAIN) err = ERR_EARLY_END;

			if (err != ERR_NONE) begin
				mode_d    = MODE_PLAIN;
				acc_d     = '0;
				hi_d      = '0;
				dc_d      = '0;
				frc_d     = 1'b0;
				err_lat_d = ~in_last;
				push      = 1'b1;
				q_cmd.err  = err;
				q_cmd.done = 1'b1;
			end else begin
				if (enc.n != 3'd0) begin
					push             = 1'b1;
					q_cmd.bytes      = enc.bytes;
					q_cmd.byte_valid = 1'b1;
					q_cmd.last_idx   = 2'(enc.n - 3'd1);
					q_cmd.done       = in_last;
					q_cmd.frc        = in_last & frc_d;
				end else if (in_last) begin
					push       = 1'b1;
					q_cmd.done = 1'b1;
					q_cmd.frc  = frc_d;
				end
				if (in_last) begin
					mode_d = MODE_PLAIN;
					acc_d  = '0;
					hi_d   = '0;
					dc_d   = '0;
					frc_d  = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			acc_q     <= '0;
			hi_q      <= '0;
			dc_q      <= '0;
			frc_q     <= 1'b0;
			err_lat_q <= 1'b0;
			utf8_q    <= 1'b0;
		end else begin
			if (cfg_we) utf8_q <= cfg_wdata;
			if (accept) begin
				mode_q    <= mode_d;
				acc_q     <= acc_d;
				hi_q      <= hi_d;
				dc_q      <= dc_d;
				frc_q     <= frc_d;
				err_lat_q <= err_lat_d;
			end
		end
	end

	`ASSERT_CLK(a_latched_plain, clk, arst_n, err_lat_q |-> (mode_q == MODE_PLAIN))
	`ASSERT_CLK(a_err_ends, clk, arst_n, (q_push && q_cmd.err != ERR_NONE) |-> (q_cmd.done && !q_cmd.byte_valid))

endmodule

FILE: src/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small request queue between the decoder and the output serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              push_ready,
	input  jsu_pkg::res_cmd_t push_cmd,
	output logic              head_valid,
	output jsu_pkg::res_cmd_t head_cmd,
	input  logic              pop
);
	import jsu_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	res_cmd_t        mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign push_ready = cnt_q != CntW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) cnt_q <= cnt_q + CntW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && cnt_q == CntW'(DEPTH))
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && cnt_q == '0)

endmodule

FILE: src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer: expands each queued request into its result items,
// one per cycle while the sink accepts them, through a registered master stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  jsu_pkg::res_cmd_t                  q_cmd,
	output logic                               q_pop,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [jsu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tuser,
	output logic                               m_axis_tlast
);
	import jsu_pkg::*;

	logic                   out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_user_q;
	logic                   out_last_q;
	logic [1:0]             idx_q;
	logic                   load;
	logic                   fin;
	logic                   ends;

	assign load  = q_valid & (~out_vld_q | m_axis_tready);
	assign fin   = idx_q == q_cmd.last_idx;
	assign ends  = fin & q_cmd.done;
	assign q_pop = load & fin;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {3'b000, ends & q_cmd.frc, ends, q_cmd.err, q_cmd.bytes[idx_q]};
			out_user_q <= q_cmd.byte_valid;
			out_last_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				idx_q     <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	`ASSERT_CLK(a_idx_bound, clk, arst_n, q_valid |-> (idx_q <= q_cmd.last_idx))

endmodule

FILE: src/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Decodes JSON string body bytes, escapes included, into UTF-8 bytes.
// ----------------------------------------------------------------------------
// The unit takes one body byte per cycle on the slave stream (tlast on the
// final byte) while the queue has room and returns decoded bytes on the
// master stream. A byte gives zero to four items; the decoder hands them as
// one request through a small queue to a serializer whose single output
// register sets the output pace of one item per cycle, so input runs at one
// byte per cycle as long as the sink keeps up and no byte gives more than
// one item. tuser high marks an item carrying a byte; items with tuser low
// report the end of a string or an error. After an error, input up to the
// next tlast is dropped without output. cfg_we writes the input_is_utf8 bit.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] out_byte, [10:8] error_code, [11] string_done, [12] force_utf8
	output logic [jsu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tuser,  // [0] byte_valid
	output logic                            m_axis_tlast
);
	import jsu_pkg::*;

	logic     push, push_ready, head_valid, pop;
	res_cmd_t push_cmd, head_cmd;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_ready  (push_ready),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	jsu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (head_valid),
		.q_cmd        (head_cmd),
		.q_pop        (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

FILE: tb/tb_json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_unit
// Self-checking bench for the JSON string unescape unit: streams string body
// bytes, predicts the decoded UTF-8 and status items, and checks each output.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_unit;
	import jsu_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       run_end;
		err_code_t  err;
		logic       done;
		logic       frc;
	} dec_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} body_req_t;

	typedef enum logic [2:0] {
		MD_PLAIN,
		MD_ESC,
		MD_HEX1,
		MD_EXP_BS,
		MD_EXP_U,
		MD_HEX2
	} dec_mode_t;

	typedef enum int {
		SEG_PLAIN,
		SEG_SIMPLE_ESC,
		SEG_U_ASCII,
		SEG_U_TWO,
		SEG_U_THREE,
		SEG_PAIR,
		SEG_BAD_ESC,
		SEG_BAD_HEX,
		SEG_LONE_LOW,
		SEG_NO_SECOND,
		SEG_NOT_PAIR,
		SEG_CUT
	} seg_kind_t;

	localparam logic [7:0] ESC_LETTERS [8] = '{CH_BSLASH, CH_SLASH, CH_QUOTE, CH_LC_B,
		CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	body_req_t   body_bytes_q[$];
	dec_item_t   decoded_q[$];
	logic [7:0]  text_q[$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned bytes_queued = 0;
	int unsigned bytes_taken = 0;
	int unsigned items_checked = 0;
	int unsigned strings_ended = 0;
	int unsigned errors_seen = 0;

	// predictor state
	logic        utf8_marked = 1'b0;
	dec_mode_t   dmode = MD_PLAIN;
	logic [15:0] hex_acc = '0;
	logic [15:0] hi_sur = '0;
	logic [1:0]  digits = '0;
	logic        force_seen = 1'b0;
	logic        err_latched = 1'b0;

	json_string_unescape_utf8_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] seq);
		seq = '0;
		if (cp < 21'h80) begin
			seq[0] = cp[7:0];
			return 1;
		end
		if (cp < 21'h800) begin
			seq[0] = {3'b110, cp[10:6]};
			seq[1] = {2'b10, cp[5:0]};
			return 2;
		end
		if (cp < 21'h10000) begin
			seq[0] = {4'b1110, cp[15:12]};
			seq[1] = {2'b10, cp[11:6]};
			seq[2] = {2'b10, cp[5:0]};
			return 3;
		end
		seq[0] = {5'b11110, cp[20:18]};
		seq[1] = {2'b10, cp[17:12]};
		seq[2] = {2'b10, cp[11:6]};
		seq[3] = {2'b10, cp[5:0]};
		return 4;
	endfunction

	function automatic void clear_decode_state();
		dmode = MD_PLAIN;
		hex_acc = '0;
		hi_sur = '0;
		digits = '0;
	endfunction

	function automatic void decode_body_byte(input logic [7:0] b, input logic fin);
		logic [3:0][7:0] seq;
		int              n;
		int              i;
		err_code_t       err;
		logic [3:0]      nib;
		logic            ishex;
		logic [20:0]     cp;
		logic            tail;
		n = 0;
		seq = '0;
		err = ERR_NONE;
		nib = '0;
		ishex = 1'b1;
		if (err_latched) begin
			if (fin)
				err_latched = 1'b0;
			return;
		end
		case (dmode)
			MD_PLAIN: begin
				if (b == CH_BSLASH)
					dmode = MD_ESC;
				else begin
					seq[0] = b;
					n = 1;
				end
			end
			MD_ESC: begin
				dmode = MD_PLAIN;
				n = 1;
				case (b)
					CH_BSLASH, CH_SLASH, CH_QUOTE: seq[0] = b;
					CH_LC_B: seq[0] = CODE_BS;
					CH_LC_F: seq[0] = CODE_FF;
					CH_LC_N: seq[0] = CODE_LF;
					CH_LC_R: seq[0] = CODE_CR;
					CH_LC_T: seq[0] = CODE_TAB;
					CH_LC_U: begin
						n = 0;
						dmode = MD_HEX1;
						hex_acc = '0;
						digits = '0;
					end
					default: begin
						n = 0;
						err = ERR_BAD_ESCAPE;
					end
				endcase
			end
			MD_HEX1, MD_HEX2: begin
				if (b >= 8'h30 && b <= 8'h39)
					nib = 4'(b - 8'h30);
				else if (b >= 8'h41 && b <= 8'h46)
					nib = 4'(b - 8'h37);
				else if (b >= 8'h61 && b <= 8'h66)
					nib = 4'(b - 8'h57);
				else
					ishex = 1'b0;
				if (!ishex)
					err = ERR_BAD_HEX;
				else begin
					hex_acc = {hex_acc[11:0], nib};
					if (digits != 2'd3)
						digits = digits + 2'd1;
					else begin
						digits = '0;
						if (dmode == MD_HEX1) begin
							if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
								hi_sur = hex_acc;
								dmode = MD_EXP_BS;
							end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
								err = ERR_LONE_LOW;
							end else begin
								n = utf8_encode({5'd0, hex_acc}, seq);
								if (hex_acc >= CP_ASCII_END && !utf8_marked)
									force_seen = 1'b1;
								dmode = MD_PLAIN;
							end
						end else begin
							if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
								cp = 21'h10000 + {1'b0, hi_sur[9:0], hex_acc[9:0]};
								n = utf8_encode(cp, seq);
								if (!utf8_marked)
									force_seen = 1'b1;
								dmode = MD_PLAIN;
							end else begin
								err = ERR_NOT_PAIR;
							end
						end
					end
				end
			end
			MD_EXP_BS: begin
				if (b == CH_BSLASH)
					dmode = MD_EXP_U;
				else
					err = ERR_NO_SECOND;
			end
			MD_EXP_U: begin
				if (b == CH_LC_U) begin
					dmode = MD_HEX2;
					hex_acc = '0;
					digits = '0;
				end else begin
					err = ERR_NO_SECOND;
				end
			end
			default: begin
				clear_decode_state();
				seq[0] = b;
				n = 1;
			end
		endcase

		if (err == ERR_NONE && fin && dmode != MD_PLAIN)
			err = ERR_EARLY_END;

		if (err != ERR_NONE) begin
			clear_decode_state();
			force_seen = 1'b0;
			if (!fin)
				err_latched = 1'b1;
			decoded_q.push_back('{8'h00, 1'b0, 1'b1, err, 1'b1, 1'b0});
			return;
		end

		if (n == 0) begin
			if (fin) begin
				decoded_q.push_back('{8'h00, 1'b0, 1'b1, ERR_NONE, 1'b1, force_seen});
				force_seen = 1'b0;
				clear_decode_state();
			end
			return;
		end

		for (i = 0; i < n; i++) begin
			tail = (i == n - 1);
			decoded_q.push_back('{seq[i], 1'b1, tail, ERR_NONE, tail && fin,
				tail && fin && force_seen});
		end
		if (fin) begin
			force_seen = 1'b0;
			clear_decode_state();
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// stimulus building

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	function automatic void emit_hex_digits(input logic [15:0] v, input int k);
		int i;
		for (i = 3; i > 3 - k; i--)
			text_q.push_back(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic void emit_uesc(input logic [15:0] v);
		text_q.push_back(CH_BSLASH);
		text_q.push_back(CH_LC_U);
		emit_hex_digits(v, 4);
	endfunction

	function automatic logic [15:0] rand_high_sur();
		return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
	endfunction

	function automatic void end_string();
		int i;
		for (i = 0; i < text_q.size(); i++)
			body_bytes_q.push_back('{text_q[i], i == text_q.size() - 1});
		bytes_queued += text_q.size();
		text_q.delete();
	endfunction

	function automatic void emit_segment(input seg_kind_t kind);
		logic [7:0]  b;
		logic [15:0] v;
		case (kind)
			SEG_PLAIN: begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_BSLASH);
				text_q.push_back(b);
			end
			SEG_SIMPLE_ESC: begin
				text_q.push_back(CH_BSLASH);
				text_q.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
			end
			SEG_U_ASCII: emit_uesc(16'($urandom_range(0, 16'h7F)));
			SEG_U_TWO: emit_uesc(16'($urandom_range(16'h80, 16'h7FF)));
			SEG_U_THREE: begin
				v = 16'($urandom_range(16'h800, 16'hFFFF));
				if (v[15:11] == 5'b11011)
					v ^= 16'h4000;
				emit_uesc(v);
			end
			SEG_PAIR: begin
				emit_uesc(rand_high_sur());
				emit_uesc(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
			end
			SEG_BAD_ESC: begin
				text_q.push_back(CH_BSLASH);
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_BSLASH || b == CH_SLASH || b == CH_QUOTE || b == CH_LC_B ||
					b == CH_LC_F || b == CH_LC_N || b == CH_LC_R || b == CH_LC_T ||
					b == CH_LC_U);
				text_q.push_back(b);
			end
			SEG_BAD_HEX: begin
				text_q.push_back(CH_BSLASH);
				text_q.push_back(CH_LC_U);
				emit_hex_digits(16'($urandom), $urandom_range(0, 3));
				do
					b = 8'($urandom_range(0, 255));
				while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
					(b >= 8'h61 && b <= 8'h66));
				text_q.push_back(b);
			end
			SEG_LONE_LOW: emit_uesc(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
			SEG_NO_SECOND: begin
				emit_uesc(rand_high_sur());
				if ($urandom_range(0, 1)) begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == CH_BSLASH);
				end else begin
					text_q.push_back(CH_BSLASH);
					do
						b = 8'($urandom_range(0, 255));
					while (b == CH_LC_U);
				end
				text_q.push_back(b);
			end
			SEG_NOT_PAIR: begin
				emit_uesc(rand_high_sur());
				v = 16'($urandom);
				if (v[15:10] == 6'b110111)
					v ^= 16'h2000;
				emit_uesc(v);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: text_q.push_back(CH_BSLASH);
					1: begin
						text_q.push_back(CH_BSLASH);
						text_q.push_back(CH_LC_U);
						emit_hex_digits(16'($urandom), $urandom_range(0, 3));
					end
					2: begin
						emit_uesc(rand_high_sur());
						if ($urandom_range(0, 1))
							text_q.push_back(CH_BSLASH);
					end
					default: begin
						emit_uesc(rand_high_sur());
						text_q.push_back(CH_BSLASH);
						text_q.push_back(CH_LC_U);
						emit_hex_digits(16'($urandom), $urandom_range(0, 3));
					end
				endcase
			end
		endcase
	endfunction

	function automatic void build_random_string();
		int        r;
		int        nseg;
		int        bad_at;
		int        k;
		seg_kind_t kind;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			nseg = $urandom_range(1, 6);
			for (k = 0; k < nseg; k++)
				text_q.push_back($urandom_range(0, 3) == 0 ? CH_BSLASH
					: 8'($urandom_range(0, 255)));
			end_string();
			return;
		end
		nseg = $urandom_range(1, 6);
		bad_at = (r < 40) ? $urandom_range(0, nseg - 1) : -1;
		for (k = 0; k < nseg; k++) begin
			if (k == bad_at) begin
				kind = seg_kind_t'($urandom_range(SEG_BAD_ESC, SEG_CUT));
				emit_segment(kind);
				if (kind == SEG_CUT)
					break;
			end else begin
				emit_segment(seg_kind_t'($urandom_range(SEG_PLAIN, SEG_PAIR)));
			end
		end
		end_string();
	endfunction

	task automatic write_cfg(input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		utf8_marked = v;
	endtask

	task automatic wait_idle();
		while (body_bytes_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input logic marked, input int unsigned idle, input int unsigned stall,
		input int unsigned count);
		int unsigned start;
		write_cfg(marked);
		idle_pct = idle;
		stall_pct = stall;
		start = bytes_queued;
		while (bytes_queued - start < count)
			build_random_string();
		wait_idle();
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (body_bytes_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= body_bytes_q[0].data;
					s_axis_tlast <= body_bytes_q[0].fin;
					void'(body_bytes_q.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// predict on accepted requests, check accepted outputs
	always @(posedge clk) begin
		dec_item_t got;
		dec_item_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_taken++;
				decode_body_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast,
					err_code_t'(m_axis_tdata[10:8]), m_axis_tdata[11], m_axis_tdata[12]};
				if (got.done)
					strings_ended++;
				if (got.err != ERR_NONE)
					errors_seen++;
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output %h", got));
				end else begin
					want = decoded_q.pop_front();
					items_checked++;
					if (got !== want)
						report_mismatch($sformatf(
							"got byte %h valid %b last %b err %0d done %b force %b, want byte %h valid %b last %b err %0d done %b force %b",
							got.data, got.valid, got.run_end, got.err, got.done, got.frc,
							want.data, want.valid, want.run_end, want.err, want.done, want.frc));
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		#3000000;
		$display("[json_string_unescape_utf8_unit] ERROR");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_cfg(1'b0);
		text_q.push_back(8'hFF);
		end_string();
		text_q.push_back(8'h00);
		end_string();
		text_q.push_back(CH_BSLASH);
		text_q.push_back(CH_LC_T);
		end_string();
		emit_uesc(16'h0000);
		end_string();
		emit_uesc(16'hDBFF);
		emit_uesc(16'hDFFF);
		end_string();
		text_q.push_back(CH_BSLASH);
		text_q.push_back(8'h71);
		text_q.push_back(8'h61);
		end_string();
		emit_uesc(16'hD800);
		text_q.push_back(8'h78);
		text_q.push_back(8'h79);
		end_string();
		text_q.push_back(CH_BSLASH);
		end_string();
		wait_idle();

		run_phase(1'b1, 0, 0, 90);
		run_phase(1'b0, 46, 0, 90);
		run_phase(1'b1, 0, 46, 90);
		run_phase(1'b0, 14, 14, 90);

		if (decoded_q.size() != 0)
			report_mismatch($sformatf("%0d outputs never arrived", decoded_q.size()));
		$display("Streamed %0d body bytes over four idle/stall mixes and both UTF-8 marks.",
			bytes_taken);
		$display("Checked %0d outputs: %0d strings ended, %0d of them by an error.",
			items_checked, strings_ended, errors_seen);
		if (mismatch_count == 0)
			$display("[json_string_unescape_utf8_unit] OK");
		else
			$display("[json_string_unescape_utf8_unit] ERROR");
		$finish;
	end

endmodule
